FILE: sv/bpdds_pkg.sv
// Shared types, constants and fixed-point helpers for the balance controller.
// Used by bpdds_mul and balance_pid_diff_drive_stepper_top; depends on nothing.
`default_nettype none

package bpdds_pkg;

   // Number format and fixed controller constants.
   localparam int FRAC_BITS = 16;
   localparam logic [31:0] SPEED_DEADZONE = 32'd327680;
   localparam logic [31:0] YAW_DEADZONE = 32'd65536;
   localparam logic [31:0] TRACK_WIDTH = 32'd10485760;
   localparam logic [31:0] STEPS_PER_UNIT = 32'd655360;
   localparam logic [30:0] FREQ_LIMIT = 31'd1310720000;
   // pi/360 as an unsigned Q0.32 fraction.
   localparam logic [31:0] HALF_RAD_PER_DEG_Q32 = 32'd37480661;

   // Multiplier product, shifted result and working widths.
   localparam int PROD_W = 64;
   localparam int RES_W = PROD_W - FRAC_BITS + 1;
   localparam int WIDE_W = RES_W + 3;
   localparam int CSR_ADDR_W = 5;

   // Reset values of the configuration registers.
   localparam logic [30:0] V_MAX_RESET = 31'd655360000;
   localparam logic [30:0] THETA_REF_LIMIT_RESET = 31'd655360;
   localparam logic [30:0] SLEW_STEP_MAX_RESET = 31'd6553600;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [RES_W-1:0] res_type;

   localparam wide_type I32_MAX = wide_type'(32'sh7fffffff);
   localparam wide_type I32_MIN = wide_type'(32'sh80000000);

   // Configuration register indexes (word address).
   typedef enum logic [2:0] {
      REG_KP,
      REG_KI_DT,
      REG_KD,
      REG_K_V,
      REG_THETA_TRIM,
      REG_V_MAX,
      REG_THETA_REF_LIMIT,
      REG_SLEW_STEP_MAX
   } reg_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_VREF,
      S_HALF,
      S_TREF,
      S_TURN,
      S_ERR,
      S_KI,
      S_KP,
      S_KD,
      S_RAW,
      S_MIX,
      S_FL,
      S_FR,
      S_SLEWL,
      S_SLEWR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic signed [31:0] tilt_deg;
      logic signed [31:0] tilt_rate_dps;
      logic signed [31:0] speed_cmd;
      logic signed [31:0] yaw_cmd;
      logic [16:0]        obstacle_scale;
      logic               link_ok;
      logic               armed;
   } req_type;

   typedef struct packed {
      logic [30:0]        freq_left;
      logic [30:0]        freq_right;
      logic               dir_left;
      logic               dir_right;
      logic signed [31:0] speed_left;
      logic signed [31:0] speed_right;
      logic signed [31:0] drive_speed;
      logic signed [31:0] tilt_ref;
   } rsp_type;

   // One request to the shared multiplier: magnitudes, result sign, shift.
   typedef struct packed {
      logic [31:0] a_mag;
      logic [31:0] b_mag;
      logic        neg;
      logic        shift_q32;
   } mul_op_type;

   // Magnitude of a 32-bit signed value; the most negative value maps to 2^31.
   function automatic logic [31:0] abs32(input logic signed [31:0] x);
      abs32 = x[31] ? (~x + 32'd1) : x;
   endfunction

   // Saturate a wide signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input wide_type x);
      if (x > I32_MAX) begin
         sat32 = I32_MAX[31:0];
      end else if (x < I32_MIN) begin
         sat32 = I32_MIN[31:0];
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   // Clamp a wide signed value to plus or minus an unsigned limit.
   function automatic wide_type clamp_sym(input wide_type x, input logic [30:0] lim);
      wide_type hi;
      wide_type lo;
      hi = wide_type'({1'b0, lim});
      lo = -hi;
      if (x > hi) begin
         clamp_sym = hi;
      end else if (x < lo) begin
         clamp_sym = lo;
      end else begin
         clamp_sym = x;
      end
   endfunction

   // A command whose magnitude lies strictly below the dead zone becomes zero.
   function automatic logic signed [31:0] dead_zone(input logic signed [31:0] x,
                                                    input logic [31:0] dz);
      dead_zone = (abs32(x) < dz) ? 32'sd0 : x;
   endfunction

   // Move prev toward target by at most dmax.
   function automatic logic [30:0] slew(input logic [30:0] prev, input logic [30:0] target,
                                        input logic [30:0] dmax);
      logic signed [32:0] diff;
      logic signed [32:0] lim;
      logic signed [32:0] step;
      logic signed [32:0] sum;
      diff = signed'({2'b00, target}) - signed'({2'b00, prev});
      lim = signed'({2'b00, dmax});
      if (diff > lim) begin
         step = lim;
      end else if (diff < -lim) begin
         step = -lim;
      end else begin
         step = diff;
      end
      sum = signed'({2'b00, prev}) + step;
      slew = sum[30:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/balance_pid_diff_drive_stepper_top.sv
// Top level of the balance controller: configuration registers, sequencer and datapath.
// Depends on bpdds_pkg and instantiates the shared multiplier bpdds_mul.
`default_nettype none

// Balance PID with differential drive for a two-wheeled stepper robot, all values
// signed Q16.16. Each accepted input transfer produces exactly one result transfer.
// Nine products share a single 32x32 multiplier in sequence, with the sums, clamps,
// integral update and slew limiting in the cycles around them. req_stall is high
// while an item is in work. The finished result sits in an output register, so the
// next item is taken while it waits for the result side; a further item waits only
// if that register is still full when the next result is done. Configuration is
// written through the APB port at byte address 4*index and should only be written
// while idle.

module balance_pid_diff_drive_stepper_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire bpdds_pkg::req_type                 req_data,
   // Result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output bpdds_pkg::rsp_type                      rsp_data,
   // Configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bpdds_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   // Configuration registers
   logic [30:0]        kp_ff, ki_dt_ff, kd_ff;
   logic signed [31:0] k_v_ff, theta_trim_ff;
   logic [30:0]        v_max_ff, theta_ref_limit_ff, slew_step_max_ff;
   logic               csr_write;
   bpdds_pkg::reg_index_type csr_index;

   // Sequencer and working registers
   bpdds_pkg::state_type state_ff, state_in;
   bpdds_pkg::req_type   in_ff;
   logic signed [31:0]   vref_ff, vref_in;
   logic signed [31:0]   half_ff, half_in;
   logic signed [31:0]   tref_ff, tref_in;
   bpdds_pkg::res_type   turn_ff, turn_in;
   logic signed [31:0]   err_ff, err_in;
   logic signed [31:0]   tent_ff, tent_in;
   bpdds_pkg::wide_type  acc_ff, acc_in;
   logic signed [31:0]   vfwd_ff, vfwd_in;
   logic signed [31:0]   vl_ff, vl_in;
   logic signed [31:0]   vr_ff, vr_in;
   logic [30:0]          tgt_l_ff, tgt_l_in;
   logic [30:0]          tgt_r_ff, tgt_r_in;
   logic signed [31:0]   integral_ff, integral_in;
   logic [30:0]          last_l_ff, last_l_in;
   logic [30:0]          last_r_ff, last_r_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bpdds_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // Shared multiplier
   bpdds_pkg::mul_op_type mul_op;
   bpdds_pkg::res_type    mul_res;
   bpdds_pkg::wide_type   res_w;

   // Intermediate values
   bpdds_pkg::wide_type vcmd_w;
   logic signed [31:0]  vcmd;
   logic signed [31:0]  yref;
   bpdds_pkg::wide_type raw;
   bpdds_pkg::wide_type vfwd_w;
   bpdds_pkg::wide_type vl_w;
   bpdds_pkg::wide_type vr_w;
   logic [30:0]         freq_res;
   logic                accept;
   logic                out_free;

   bpdds_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .res   (mul_res)
   );

   assign res_w = bpdds_pkg::wide_type'(mul_res);

   // Handshake signals.
   assign req_stall = (state_ff != bpdds_pkg::S_IDLE);
   assign accept    = req_valid && (state_ff == bpdds_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes and reads.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = bpdds_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff              <= '0;
         ki_dt_ff           <= '0;
         kd_ff              <= '0;
         k_v_ff             <= '0;
         theta_trim_ff      <= '0;
         v_max_ff           <= bpdds_pkg::V_MAX_RESET;
         theta_ref_limit_ff <= bpdds_pkg::THETA_REF_LIMIT_RESET;
         slew_step_max_ff   <= bpdds_pkg::SLEW_STEP_MAX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bpdds_pkg::REG_KP:              kp_ff              <= csr_pwdata[30:0];
            bpdds_pkg::REG_KI_DT:           ki_dt_ff           <= csr_pwdata[30:0];
            bpdds_pkg::REG_KD:              kd_ff              <= csr_pwdata[30:0];
            bpdds_pkg::REG_K_V:             k_v_ff             <= csr_pwdata;
            bpdds_pkg::REG_THETA_TRIM:      theta_trim_ff      <= csr_pwdata;
            bpdds_pkg::REG_V_MAX:           v_max_ff           <= csr_pwdata[30:0];
            bpdds_pkg::REG_THETA_REF_LIMIT: theta_ref_limit_ff <= csr_pwdata[30:0];
            bpdds_pkg::REG_SLEW_STEP_MAX:   slew_step_max_ff   <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bpdds_pkg::REG_KP:              csr_prdata = {1'b0, kp_ff};
         bpdds_pkg::REG_KI_DT:           csr_prdata = {1'b0, ki_dt_ff};
         bpdds_pkg::REG_KD:              csr_prdata = {1'b0, kd_ff};
         bpdds_pkg::REG_K_V:             csr_prdata = k_v_ff;
         bpdds_pkg::REG_THETA_TRIM:      csr_prdata = theta_trim_ff;
         bpdds_pkg::REG_V_MAX:           csr_prdata = {1'b0, v_max_ff};
         bpdds_pkg::REG_THETA_REF_LIMIT: csr_prdata = {1'b0, theta_ref_limit_ff};
         bpdds_pkg::REG_SLEW_STEP_MAX:   csr_prdata = {1'b0, slew_step_max_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   // Conditioned commands: dead zones, speed limit and link loss.
   assign vcmd_w = bpdds_pkg::clamp_sym(
                      bpdds_pkg::wide_type'(bpdds_pkg::dead_zone(in_ff.speed_cmd,
                                                                 bpdds_pkg::SPEED_DEADZONE)),
                      v_max_ff);
   assign vcmd = vcmd_w[31:0];
   assign yref = in_ff.link_ok ?
                 bpdds_pkg::dead_zone(in_ff.yaw_cmd, bpdds_pkg::YAW_DEADZONE) : 32'sd0;

   // PID sum, forward speed and wheel mixing.
   assign raw    = acc_ff - res_w;
   assign vfwd_w = bpdds_pkg::clamp_sym(raw, v_max_ff);
   assign vl_w   = bpdds_pkg::clamp_sym(bpdds_pkg::wide_type'(vfwd_ff)
                                        - bpdds_pkg::wide_type'(turn_ff), v_max_ff);
   assign vr_w   = bpdds_pkg::clamp_sym(bpdds_pkg::wide_type'(vfwd_ff)
                                        + bpdds_pkg::wide_type'(turn_ff), v_max_ff);

   // Step frequency from a wheel speed product, clamped to the limit.
   assign freq_res = (res_w > bpdds_pkg::wide_type'({1'b0, bpdds_pkg::FREQ_LIMIT})) ?
                     bpdds_pkg::FREQ_LIMIT : mul_res[30:0];

   // Next state: a fixed walk through the products, then wait for the output register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpdds_pkg::S_IDLE:  if (accept) state_in = bpdds_pkg::S_VREF;
         bpdds_pkg::S_VREF:  state_in = bpdds_pkg::S_HALF;
         bpdds_pkg::S_HALF:  state_in = bpdds_pkg::S_TREF;
         bpdds_pkg::S_TREF:  state_in = bpdds_pkg::S_TURN;
         bpdds_pkg::S_TURN:  state_in = bpdds_pkg::S_ERR;
         bpdds_pkg::S_ERR:   state_in = bpdds_pkg::S_KI;
         bpdds_pkg::S_KI:    state_in = bpdds_pkg::S_KP;
         bpdds_pkg::S_KP:    state_in = bpdds_pkg::S_KD;
         bpdds_pkg::S_KD:    state_in = bpdds_pkg::S_RAW;
         bpdds_pkg::S_RAW:   state_in = bpdds_pkg::S_MIX;
         bpdds_pkg::S_MIX:   state_in = bpdds_pkg::S_FL;
         bpdds_pkg::S_FL:    state_in = bpdds_pkg::S_FR;
         bpdds_pkg::S_FR:    state_in = bpdds_pkg::S_SLEWL;
         bpdds_pkg::S_SLEWL: state_in = bpdds_pkg::S_SLEWR;
         bpdds_pkg::S_SLEWR: state_in = bpdds_pkg::S_DONE;
         bpdds_pkg::S_DONE:  if (out_free) state_in = bpdds_pkg::S_IDLE;
         default:            state_in = bpdds_pkg::S_IDLE;
      endcase
   end

   // Per-state multiplier requests and working register updates. A state issues at most
   // one product, and each product is consumed in the state after the one that issued it.
   always_comb begin
      mul_op       = '0;
      vref_in      = vref_ff;
      half_in      = half_ff;
      tref_in      = tref_ff;
      turn_in      = turn_ff;
      err_in       = err_ff;
      tent_in      = tent_ff;
      acc_in       = acc_ff;
      vfwd_in      = vfwd_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      tgt_l_in     = tgt_l_ff;
      tgt_r_in     = tgt_r_ff;
      integral_in  = integral_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bpdds_pkg::S_VREF: begin
            mul_op = '{a_mag: bpdds_pkg::abs32(vcmd), b_mag: {15'd0, in_ff.obstacle_scale},
                       neg: vcmd[31], shift_q32: 1'b0};
         end
         bpdds_pkg::S_HALF: begin
            mul_op = '{a_mag: bpdds_pkg::abs32(yref), b_mag: bpdds_pkg::HALF_RAD_PER_DEG_Q32,
                       neg: yref[31], shift_q32: 1'b1};
            vref_in = in_ff.link_ok ? bpdds_pkg::sat32(res_w) : 32'sd0;
         end
         bpdds_pkg::S_TREF: begin
            mul_op = '{a_mag: bpdds_pkg::abs32(k_v_ff), b_mag: bpdds_pkg::abs32(vref_ff),
                       neg: k_v_ff[31] ^ vref_ff[31], shift_q32: 1'b0};
            half_in = mul_res[31:0];
         end
         bpdds_pkg::S_TURN: begin
            mul_op = '{a_mag: bpdds_pkg::abs32(half_ff), b_mag: bpdds_pkg::TRACK_WIDTH,
                       neg: half_ff[31], shift_q32: 1'b0};
            tref_in = bpdds_pkg::sat32(bpdds_pkg::clamp_sym(res_w, theta_ref_limit_ff)
                                       + bpdds_pkg::wide_type'(theta_trim_ff));
         end
         bpdds_pkg::S_ERR: begin
            turn_in = mul_res;
            err_in  = bpdds_pkg::sat32(bpdds_pkg::wide_type'(tref_ff)
                                       - bpdds_pkg::wide_type'(in_ff.tilt_deg));
         end
         bpdds_pkg::S_KI: begin
            mul_op = '{a_mag: {1'b0, ki_dt_ff}, b_mag: bpdds_pkg::abs32(err_ff),
                       neg: err_ff[31], shift_q32: 1'b0};
         end
         bpdds_pkg::S_KP: begin
            mul_op = '{a_mag: {1'b0, kp_ff}, b_mag: bpdds_pkg::abs32(err_ff),
                       neg: err_ff[31], shift_q32: 1'b0};
            tent_in = bpdds_pkg::sat32(bpdds_pkg::wide_type'(integral_ff) + res_w);
         end
         bpdds_pkg::S_KD: begin
            mul_op = '{a_mag: {1'b0, kd_ff}, b_mag: bpdds_pkg::abs32(in_ff.tilt_rate_dps),
                       neg: in_ff.tilt_rate_dps[31], shift_q32: 1'b0};
            acc_in = res_w + bpdds_pkg::wide_type'(tent_ff);
         end
         bpdds_pkg::S_RAW: begin
            // Conditional integration: keep the new integral only when unclamped; clear it when disarmed.
            vfwd_in = vfwd_w[31:0];
            if (!in_ff.armed) begin
               integral_in = 32'sd0;
            end else if (vfwd_w == raw) begin
               integral_in = tent_ff;
            end
         end
         bpdds_pkg::S_MIX: begin
            vl_in = vl_w[31:0];
            vr_in = vr_w[31:0];
         end
         bpdds_pkg::S_FL: begin
            mul_op = '{a_mag: bpdds_pkg::abs32(vl_ff), b_mag: bpdds_pkg::STEPS_PER_UNIT,
                       neg: 1'b0, shift_q32: 1'b0};
         end
         bpdds_pkg::S_FR: begin
            mul_op = '{a_mag: bpdds_pkg::abs32(vr_ff), b_mag: bpdds_pkg::STEPS_PER_UNIT,
                       neg: 1'b0, shift_q32: 1'b0};
            tgt_l_in = in_ff.armed ? freq_res : 31'd0;
         end
         bpdds_pkg::S_SLEWL: begin
            tgt_r_in  = in_ff.armed ? freq_res : 31'd0;
            last_l_in = bpdds_pkg::slew(last_l_ff, tgt_l_ff, slew_step_max_ff);
         end
         bpdds_pkg::S_SLEWR: begin
            last_r_in = bpdds_pkg::slew(last_r_ff, tgt_r_ff, slew_step_max_ff);
         end
         bpdds_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{freq_left: last_l_ff, freq_right: last_r_ff,
                                dir_left: !vl_ff[31], dir_right: !vr_ff[31],
                                speed_left: vl_ff, speed_right: vr_ff,
                                drive_speed: vfwd_ff, tilt_ref: tref_ff};
            end
         end
         default: ;
      endcase
   end

   // Control state and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpdds_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      vref_ff     <= vref_in;
      half_ff     <= half_in;
      tref_ff     <= tref_in;
      turn_ff     <= turn_in;
      err_ff      <= err_in;
      tent_ff     <= tent_in;
      acc_ff      <= acc_in;
      vfwd_ff     <= vfwd_in;
      vl_ff       <= vl_in;
      vr_ff       <= vr_in;
      tgt_l_ff    <= tgt_l_in;
      tgt_r_ff    <= tgt_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: sv/bpdds_mul.sv
// Shared 32x32 unsigned multiplier with a registered product, then shift and sign.
// Depends on bpdds_pkg for the request type and result width.
`default_nettype none

module bpdds_mul (
   input  wire logic                 clock,
   input  wire bpdds_pkg::mul_op_type op,
   output bpdds_pkg::res_type        res
);

   logic [bpdds_pkg::PROD_W-1:0] prod_ff;
   logic                         neg_ff;
   logic                         shift_q32_ff;
   logic [bpdds_pkg::PROD_W-1:0] shifted;
   logic [bpdds_pkg::RES_W-2:0]  mag;

   // Product register; the result is consumed in the cycle after the request.
   always_ff @(posedge clock) begin
      prod_ff      <= bpdds_pkg::PROD_W'(op.a_mag) * bpdds_pkg::PROD_W'(op.b_mag);
      neg_ff       <= op.neg;
      shift_q32_ff <= op.shift_q32;
   end

   // Truncate the magnitude toward zero, then apply the sign.
   assign shifted = shift_q32_ff ? (prod_ff >> 32) : (prod_ff >> bpdds_pkg::FRAC_BITS);
   assign mag = shifted[bpdds_pkg::RES_W-2:0];
   assign res = neg_ff ? -signed'({1'b0, mag}) : signed'({1'b0, mag});

endmodule

`default_nettype wire
